[design/day_phase_color_ramp_macros.svh]
// Assertion macros used by the day phase color ramp top level.
`ifndef DAY_PHASE_COLOR_RAMP_MACROS_SVH
`define DAY_PHASE_COLOR_RAMP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dpcr_pkg.sv]
// Shared types, keyframe tables and codes for the day phase color ramp.
`timescale 1ns / 1ps
package dpcr_pkg;

  localparam int PHASE_BITS = 16;
  localparam int KEY_COUNT  = 8;
  localparam int SEG_COUNT  = KEY_COUNT - 1;
  localparam int SEG_W      = $clog2(KEY_COUNT);
  localparam int CHAN_COUNT = 4;
  localparam int CHAN_W     = $clog2(CHAN_COUNT);
  localparam int FACTOR_W   = 16;
  localparam int RECIP_W    = 21;
  localparam int PROD_W     = FACTOR_W + RECIP_W;
  localparam int STEP_W     = 16;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [7:0]            chan_t;
  typedef logic [RECIP_W-1:0]    recip_t;
  typedef logic [FACTOR_W-1:0]   factor_t;

  // Operation codes carried in the input tuser.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Register index taken from the word address.
  localparam logic [ADDR_W-3:0] REG_PHASE_STEP = '0;

  // Shared unit modes.
  localparam logic ALU_FACTOR = 1'b0;
  localparam logic ALU_BLEND  = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET  = 16'd66;
  localparam phase_t            PHASE_RESET = phase_t'(1) << (PHASE_BITS - 2);

  // Segment start times: round(k/1000 of a day) in 0.16 format.
  localparam phase_t KEY_TIME [SEG_COUNT] = '{
    16'd0, 16'd13107, 16'd16384, 16'd22938, 16'd42598, 16'd49152, 16'd55706
  };

  // round(2^32 / segment length) for each segment.
  localparam recip_t SEG_RECIP [SEG_COUNT] = '{
    21'd327685, 21'd1310640, 21'd655320, 21'd218462,
    21'd655320, 21'd655320, 21'd436924
  };

  // Keyframe colors as red, green, blue, alpha.
  localparam chan_t KEY_RGBA [KEY_COUNT][CHAN_COUNT] = '{
    '{8'd10,  8'd10,  8'd50, 8'd190},
    '{8'd20,  8'd30,  8'd90, 8'd100},
    '{8'd250, 8'd230, 8'd80, 8'd30},
    '{8'd0,   8'd0,   8'd0,  8'd0},
    '{8'd0,   8'd0,   8'd0,  8'd0},
    '{8'd240, 8'd130, 8'd60, 8'd45},
    '{8'd15,  8'd5,   8'd30, 8'd150},
    '{8'd10,  8'd10,  8'd50, 8'd190}
  };

  typedef struct packed {
    logic    mode;
    factor_t mult;
    recip_t  coef;
    chan_t   lo;
    chan_t   hi;
  } alu_req_t;

endpackage

[design/dpcr_regs.sv]
// Configuration register file with an APB-style port.
`timescale 1ns / 1ps
module dpcr_regs import dpcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [STEP_W-1:0] phase_step
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[ADDR_W-1:2] == REG_PHASE_STEP);
  assign prdata = hit ? DATA_W'(phase_step) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      phase_step <= pwdata[STEP_W-1:0];
    end
  end

endmodule

[design/dpcr_alu.sv]
// Shared multiplier unit: forms the segment factor or blends one color channel.
`timescale 1ns / 1ps
module dpcr_alu import dpcr_pkg::*; (
  input  alu_req_t req,
  output factor_t  result
);

  recip_t              coef;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_up;
  logic                rising;

  always_comb begin
    rising  = (req.hi >= req.lo);
    if (req.mode == ALU_BLEND) begin
      coef = rising ? RECIP_W'(req.hi - req.lo) : RECIP_W'(req.lo - req.hi);
    end else begin
      coef = req.coef;
    end
    prod    = PROD_W'(req.mult) * PROD_W'(coef);
    prod_up = prod + PROD_W'(16'hFFFF);

    if (req.mode == ALU_BLEND) begin
      // A falling channel rounds the step up so the result floors overall.
      if (rising) begin
        result = FACTOR_W'(req.lo + prod[23:16]);
      end else begin
        result = FACTOR_W'(req.lo - prod_up[23:16]);
      end
    end else if (|prod[PROD_W-1:PHASE_BITS+FACTOR_W]) begin
      result = '1;
    end else begin
      result = prod[PHASE_BITS+FACTOR_W-1:PHASE_BITS];
    end
  end

endmodule

[design/dpcr_core.sv]
// Phase register, segment search and the sequencer around the shared unit.
`timescale 1ns / 1ps
module dpcr_core import dpcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [STEP_W-1:0]      phase_step,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output alu_req_t               alu_req,
  input  factor_t                alu_result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEG    = 3'd1;
  localparam logic [2:0] ST_FACTOR = 3'd2;
  localparam logic [2:0] ST_BLEND  = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  phase_t           day_phase;
  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] seg_up;
  logic [SEG_W-1:0] seg_hit;
  phase_t           seg_offset;
  factor_t          factor;
  logic [CHAN_W-1:0] chan;
  chan_t            color [CHAN_COUNT];
  logic             out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign seg_up   = seg + 1'b1;

  // Last segment whose start is at or below the phase.
  always_comb begin
    seg_hit = '0;
    for (int k = 1; k < SEG_COUNT; k++) begin
      if (KEY_TIME[k] <= day_phase) seg_hit = SEG_W'(k);
    end
  end

  always_comb begin
    alu_req.mode = (state == ST_BLEND) ? ALU_BLEND : ALU_FACTOR;
    alu_req.mult = (state == ST_BLEND) ? factor : FACTOR_W'(seg_offset);
    alu_req.coef = SEG_RECIP[seg];
    alu_req.lo   = KEY_RGBA[seg][chan];
    alu_req.hi   = KEY_RGBA[seg_up][chan];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SEG;
      ST_SEG:    state_next = ST_FACTOR;
      ST_FACTOR: state_next = ST_BLEND;
      ST_BLEND:  if (chan == CHAN_W'(CHAN_COUNT - 1)) state_next = ST_HOLD;
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      day_phase <= PHASE_RESET;
      m_tvalid  <= 1'b0;
      chan      <= '0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_LOAD) begin
          day_phase <= s_tdata[PHASE_BITS-1:0];
        end else begin
          day_phase <= day_phase + PHASE_BITS'(phase_step);
        end
      end
      if (state == ST_HOLD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_BLEND) begin
        chan <= chan + 1'b1;
      end else begin
        chan <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEG) begin
      seg        <= seg_hit;
      seg_offset <= day_phase - KEY_TIME[seg_hit];
    end
    if (state == ST_FACTOR) begin
      factor <= alu_result;
    end
    if (state == ST_BLEND) begin
      color[chan] <= alu_result[7:0];
    end
    if (state == ST_HOLD && out_free) begin
      m_tdata <= {color[3], color[2], color[1], color[0], 16'(day_phase)};
    end
  end

endmodule

[design/day_phase_color_ramp.sv]
// Top level of the day phase color ramp: phase clock with an RGBA keyframe ramp.
//
// Input stream (s_t*): one word per item. s_tuser is the operation (tick adds
// the configured step to the phase and wraps at one day, load replaces the
// phase with s_tdata). Each accepted word yields exactly one output word on
// m_t* with the new phase and the interpolated red, green, blue and alpha.
// The sequencer runs a segment search, then one pass through the shared
// multiplier for the factor and one per color channel, then the output
// load. s_tready is low while a word is being worked on, so the next word
// is taken only after the sequencer has finished with the last one.
// The result sits in an output register, so s_tready returns while m_tvalid
// is still waiting; if the receiver stalls with that register full, the next
// result waits in the core and s_tready stays low until it moves out.
// Reset (rst, synchronous) sets the phase to a quarter day, the step to 66
// and empties the output. phase_step is written through the APB port at
// byte address 0; the user must do so while the block is idle (not enforced).
`timescale 1ns / 1ps
module day_phase_color_ramp import dpcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] new_phase
  input  logic                   s_tuser,   // [0] func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [15:0] phase, [23:16] red,
                                            // [31:24] green, [39:32] blue,
                                            // [47:40] alpha
);

`include "day_phase_color_ramp_macros.svh"

  logic [STEP_W-1:0] phase_step;
  alu_req_t          alu_req;
  factor_t           alu_result;

  dpcr_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .phase_step (phase_step)
  );

  dpcr_alu u_alu (
    .req    (alu_req),
    .result (alu_result)
  );

  dpcr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .phase_step (phase_step),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .alu_req    (alu_req),
    .alu_result (alu_result)
  );

  `DPCR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
    "input accepted while a word is still in progress")
  `DPCR_ASSERT_NOW(a_ready_on_result, $rose(m_tvalid), s_tready,
    "sequencer not idle when a result was delivered")
  `DPCR_ASSERT_NEXT(a_step_write,
    psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_PHASE_STEP,
    phase_step == $past(pwdata[STEP_W-1:0]),
    "phase step register did not take the written word")

endmodule
